// ===== hdl/lmss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared types and constants of the scrolling LED matrix scanner.
// ----------------------------------------------------------------------------
package lmss_pkg;

    // item kinds on the input stream
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_DWELL_TICKS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_PER_SHIFT = 2'd1;

    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] DWELL_RESET  = 16'd1;
    localparam logic [7:0]  FRAMES_RESET = 8'd10;

    // output line counts are fixed by the 8-bit ports
    localparam int unsigned LINES = 8;

    typedef struct packed {
        logic       character_done;
        logic       shift_pulse;
        logic [7:0] column_lines;
        logic [7:0] row_lines_n;
    } result_t;

endpackage

// ===== hdl/lmss_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmss_core
// Scan position, dwell and frame counters, frame and glyph stores; forms the
// line drive of the current pixel for every accepted transaction.
// ----------------------------------------------------------------------------
module lmss_core #(
    parameter int unsigned MATRIX_SIZE = 8
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_fire,
    input  logic                                   cmd,
    input  logic [2:0]                             row_index,
    input  logic [7:0]                             glyph_bits,
    input  logic                                   cfg_we,
    input  logic [lmss_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [lmss_pkg::CFG_DATA_W-1:0]        cfg_data,
    output lmss_pkg::result_t                      result
);

    localparam int unsigned IDX_W = $clog2(MATRIX_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_SIZE - 1);

    logic [15:0] dwell_ticks_reg;
    logic [7:0]  frames_per_shift_reg;

    logic [MATRIX_SIZE-1:0] frame_bits_reg [MATRIX_SIZE];
    logic [MATRIX_SIZE-1:0] frame_bits_next [MATRIX_SIZE];
    logic [7:0]             next_glyph_reg [MATRIX_SIZE];

    logic [IDX_W-1:0] scan_row_reg, scan_row_next;
    logic [IDX_W-1:0] scan_column_reg, scan_column_next;
    logic [IDX_W-1:0] shift_step_reg, shift_step_next;
    logic [15:0]      dwell_count_reg, dwell_count_next;
    logic [7:0]       frame_count_reg, frame_count_next;

    logic [15:0]            dwell_eff;
    logic [7:0]             frames_eff;
    logic [15:0]            dwell_inc;
    logic [7:0]             frame_inc;
    logic                   shift_now;
    logic                   done_now;
    logic                   is_tick;
    logic [MATRIX_SIZE-1:0] glyph_ext;
    logic [7:0]             pixel_row;
    logic [7:0]             row_n;
    logic [7:0]             cols;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dwell_ticks_reg      <= lmss_pkg::DWELL_RESET;
            frames_per_shift_reg <= lmss_pkg::FRAMES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lmss_pkg::REG_DWELL_TICKS:      dwell_ticks_reg <= cfg_data;
                lmss_pkg::REG_FRAMES_PER_SHIFT: frames_per_shift_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // line drive of the pixel shown now
    always_comb
    begin
        pixel_row = 8'(frame_bits_reg[scan_row_reg]);
        for (int i = 0; i < lmss_pkg::LINES; i++)
        begin
            row_n[i] = (int'(scan_row_reg) != i);
            cols[i]  = (int'(scan_column_reg) == i) && pixel_row[i];
        end
    end

    // scan advance
    always_comb
    begin
        dwell_eff  = (dwell_ticks_reg == 16'd0) ? 16'd1 : dwell_ticks_reg;
        frames_eff = (frames_per_shift_reg == 8'd0) ? 8'd1 : frames_per_shift_reg;
        is_tick    = item_fire && (cmd == lmss_pkg::CMD_TICK);
        dwell_inc  = dwell_count_reg + 16'd1;
        frame_inc  = frame_count_reg + 8'd1;
        glyph_ext  = MATRIX_SIZE'(next_glyph_reg[shift_step_reg]);

        dwell_count_next  = dwell_count_reg;
        scan_column_next  = scan_column_reg;
        scan_row_next     = scan_row_reg;
        frame_count_next  = frame_count_reg;
        shift_step_next   = shift_step_reg;
        shift_now         = 1'b0;
        done_now          = 1'b0;

        if (is_tick)
        begin
            dwell_count_next = dwell_inc;
            if (dwell_inc >= dwell_eff)
            begin
                dwell_count_next = 16'd0;
                if (scan_column_reg != LAST_IDX)
                    scan_column_next = scan_column_reg + 1'b1;
                else
                begin
                    scan_column_next = '0;
                    if (scan_row_reg != LAST_IDX)
                        scan_row_next = scan_row_reg + 1'b1;
                    else
                    begin
                        scan_row_next    = '0;
                        frame_count_next = frame_inc;
                        if (frame_inc >= frames_eff)
                        begin
                            frame_count_next = 8'd0;
                            shift_now        = 1'b1;
                            if (shift_step_reg != LAST_IDX)
                                shift_step_next = shift_step_reg + 1'b1;
                            else
                            begin
                                shift_step_next = '0;
                                done_now        = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        // drop column 0, bring the glyph column in at the top bit
        for (int i = 0; i < MATRIX_SIZE; i++)
            frame_bits_next[i] = {glyph_ext[i], frame_bits_reg[i][MATRIX_SIZE-1:1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg    <= '0;
            scan_column_reg <= '0;
            shift_step_reg  <= '0;
            dwell_count_reg <= '0;
            frame_count_reg <= '0;
            for (int i = 0; i < MATRIX_SIZE; i++)
            begin
                frame_bits_reg[i] <= '0;
                next_glyph_reg[i] <= '0;
            end
        end
        else
        begin
            scan_row_reg    <= scan_row_next;
            scan_column_reg <= scan_column_next;
            shift_step_reg  <= shift_step_next;
            dwell_count_reg <= dwell_count_next;
            frame_count_reg <= frame_count_next;
            if (shift_now)
            begin
                for (int i = 0; i < MATRIX_SIZE; i++)
                    frame_bits_reg[i] <= frame_bits_next[i];
            end
            if (item_fire && (cmd == lmss_pkg::CMD_WRITE) &&
                (int'(row_index) < MATRIX_SIZE))
                next_glyph_reg[IDX_W'(row_index)] <= glyph_bits;
        end
    end

    assign result.row_lines_n    = row_n;
    assign result.column_lines   = cols;
    assign result.shift_pulse    = shift_now;
    assign result.character_done = done_now;

    a_done_implies_shift: assert property (@(posedge clk) disable iff (!rst_n)
        done_now |-> shift_now)
        else $error("character_done without a shift");

    a_done_wraps_step: assert property (@(posedge clk) disable iff (!rst_n)
        done_now |=> (shift_step_reg == '0))
        else $error("shift step did not wrap after character_done");

    a_column_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !is_tick |=> $stable(scan_column_reg) && $stable(scan_row_reg))
        else $error("scan moved without a tick");

endmodule

// ===== hdl/lmss_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmss_out_buf
// Two-entry result buffer: output register plus skid register, so the input
// ready depends on registered state only.
// ----------------------------------------------------------------------------
module lmss_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  lmss_pkg::result_t in_data,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lmss_pkg::result_t out_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    lmss_pkg::result_t out_data_reg, out_data_next;
    lmss_pkg::result_t skid_data_reg, skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            // refill from skid first; input is held off while skid is full
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = in_data;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !out_valid_reg |=> out_valid_reg && !skid_valid_reg)
        else $error("accepted transaction did not reach the output register");

endmodule

// ===== hdl/led_matrix_scroll_scanner_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_scroll_scanner_top
// Scrolling LED matrix scanner: pixel-at-a-time drive with glyph scroll-in.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock cycle while s_tready is high and
// each produces exactly one result transaction, presented on the master
// side from the output register. The scan state advances only on accepted
// ticks; a two-entry output buffer (output register plus skid) keeps
// s_tready registered. While a result waits, one more transaction is taken
// into the skid entry, and s_tready then stays low until the receiver
// drains the output register. Configuration writes are never stalled
// (cfg_ready is always high) and must be issued while idle.
// ----------------------------------------------------------------------------
module led_matrix_scroll_scanner_top #(
    parameter int unsigned MATRIX_SIZE = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // row_index[2:0], glyph_bits[10:3]
    input  logic                               s_tuser,   // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // row_lines_n[7:0], column_lines[15:8]
    output logic                               m_tuser,   // shift_pulse
    output logic                               m_tlast,   // character_done
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lmss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lmss_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic              item_fire;
    logic              buf_ready;
    lmss_pkg::result_t core_result;
    lmss_pkg::result_t out_result;

    assign item_fire = s_tvalid && buf_ready;
    assign s_tready  = buf_ready;
    assign cfg_ready = 1'b1;

    lmss_core #(
        .MATRIX_SIZE (MATRIX_SIZE)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_fire  (item_fire),
        .cmd        (s_tuser),
        .row_index  (s_tdata[2:0]),
        .glyph_bits (s_tdata[10:3]),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .result     (core_result)
    );

    lmss_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (item_fire),
        .in_data   (core_result),
        .in_ready  (buf_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {out_result.column_lines, out_result.row_lines_n};
    assign m_tuser = out_result.shift_pulse;
    assign m_tlast = out_result.character_done;

endmodule

// ===== bench/led_matrix_scroll_scanner_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_scroll_scanner_top_tb
// Self-checking bench for the scrolling LED matrix scanner.
// ----------------------------------------------------------------------------
// Glyph-row writes and scan ticks go in on the slave stream. Each one is run
// through a local model of the scan, the pixel drive and the scroll, and the
// predicted line drive is queued. Every result on the master stream is
// compared field by field with the oldest queued drive. Register settings
// cover the extremes, zero values, an unused index and fast-scroll settings.
// Both stream sides idle at random, and one long receiver hold-off fills the
// block up so that it stalls its input.
// ----------------------------------------------------------------------------
module led_matrix_scroll_scanner_top_tb;

    localparam logic [lmss_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int ITEM_TARGET  = 1100;
    localparam int ITEM_CAP     = 2600;
    localparam int PHASE_ITEMS  = 140;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [15:0]                      s_tdata;
    logic                             s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [15:0]                      m_tdata;
    logic                             m_tuser;
    logic                             m_tlast;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [lmss_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lmss_pkg::CFG_DATA_W-1:0]  cfg_data;

    // local copy of the scanner state
    logic [7:0]  lit_frame [8];
    logic [7:0]  glyph_rows [8];
    logic [2:0]  scan_row_q;
    logic [2:0]  scan_col_q;
    logic [15:0] dwell_cnt;
    logic [7:0]  frame_cnt;
    logic [2:0]  shift_idx;
    logic [15:0] dwell_setting;
    logic [7:0]  frames_setting;

    lmss_pkg::result_t expected_drive_q [$];

    int error_count;
    int cycle_count;
    int random_items;
    int chars_scrolled;
    int send_gap_max;
    int recv_gap_max;
    int ready_wait;
    int hold_off_left;

    led_matrix_scroll_scanner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    endtask

    // Shows the pixel at the current position, then applies the item.
    function automatic lmss_pkg::result_t scan_and_drive(input logic cmd, input logic [2:0] row,
                                                         input logic [7:0] glyph);
        lmss_pkg::result_t drive;
        logic [15:0]       dwell_eff;
        logic [7:0]        frames_eff;
        int                i;
        drive.row_lines_n    = ~(8'd1 << scan_row_q);
        drive.column_lines   = lit_frame[scan_row_q][scan_col_q] ? (8'd1 << scan_col_q) : 8'd0;
        drive.shift_pulse    = 1'b0;
        drive.character_done = 1'b0;
        dwell_eff  = (dwell_setting == 16'd0) ? 16'd1 : dwell_setting;
        frames_eff = (frames_setting == 8'd0) ? 8'd1 : frames_setting;
        if (cmd == lmss_pkg::CMD_WRITE)
        begin
            glyph_rows[row] = glyph;
        end
        else
        begin
            dwell_cnt = dwell_cnt + 16'd1;
            if (dwell_cnt >= dwell_eff)
            begin
                dwell_cnt = 16'd0;
                if (scan_col_q != 3'd7)
                begin
                    scan_col_q = scan_col_q + 3'd1;
                end
                else
                begin
                    scan_col_q = 3'd0;
                    if (scan_row_q != 3'd7)
                    begin
                        scan_row_q = scan_row_q + 3'd1;
                    end
                    else
                    begin
                        scan_row_q = 3'd0;
                        frame_cnt  = frame_cnt + 8'd1;
                        if (frame_cnt >= frames_eff)
                        begin
                            frame_cnt = 8'd0;
                            // row line i takes bit i of the glyph row for this step
                            for (i = 0; i < 8; i++)
                                lit_frame[i] = {glyph_rows[shift_idx][i], lit_frame[i][7:1]};
                            drive.shift_pulse    = 1'b1;
                            drive.character_done = (shift_idx == 3'd7);
                            shift_idx = shift_idx + 3'd1;
                        end
                    end
                end
            end
        end
        return drive;
    endfunction

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_item(input logic cmd, input logic [2:0] row, input logic [7:0] glyph);
        int                gap;
        lmss_pkg::result_t drive;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {5'd0, glyph, row};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        drive = scan_and_drive(cmd, row, glyph);
        expected_drive_q.push_back(drive);
        if (drive.character_done)
            chars_scrolled++;
        @(negedge clk);
    endtask

    task automatic send_random_item();
        logic cmd;
        cmd = ($urandom_range(0, 99) < 6) ? lmss_pkg::CMD_WRITE : lmss_pkg::CMD_TICK;
        send_item(cmd, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        s_tvalid = 1'b0;
        while (expected_drive_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [lmss_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [lmss_pkg::CFG_DATA_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == lmss_pkg::REG_DWELL_TICKS)
            dwell_setting = value;
        else if (idx == lmss_pkg::REG_FRAMES_PER_SHIFT)
            frames_setting = value[7:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_scan_rate(input logic [15:0] dwell, input logic [7:0] frames);
        wait_drained();
        write_register(lmss_pkg::REG_DWELL_TICKS, dwell);
        // upper byte is not part of the frame count; send noise there
        write_register(lmss_pkg::REG_FRAMES_PER_SHIFT, {8'($urandom_range(0, 255)), frames});
    endtask

    // Receiver: long hold-off first, then the per-result random stall.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                m_tready = 1'b0;
            end
            else if (ready_wait > 0)
            begin
                ready_wait--;
                m_tready = 1'b0;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        lmss_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_drive_q.size() == 0)
            begin
                report_mismatch("result with nothing expected",
                                int'({m_tlast, m_tuser, m_tdata}), 0);
            end
            else
            begin
                want = expected_drive_q.pop_front();
                if (m_tdata[7:0] !== want.row_lines_n)
                    report_mismatch("row_lines_n", int'(m_tdata[7:0]),
                                    int'(want.row_lines_n));
                if (m_tdata[15:8] !== want.column_lines)
                    report_mismatch("column_lines", int'(m_tdata[15:8]),
                                    int'(want.column_lines));
                if (m_tuser !== want.shift_pulse)
                    report_mismatch("shift_pulse", int'(m_tuser), int'(want.shift_pulse));
                if (m_tlast !== want.character_done)
                    report_mismatch("character_done", int'(m_tlast),
                                    int'(want.character_done));
            end
            ready_wait = $urandom_range(0, recv_gap_max);
        end
    end

    task automatic test_reset_state();
        send_gap_max = 4;
        recv_gap_max = 4;
        send_item(lmss_pkg::CMD_TICK, 3'd0, 8'h00);
        send_item(lmss_pkg::CMD_WRITE, 3'd0, 8'hFF);
        send_item(lmss_pkg::CMD_WRITE, 3'd7, 8'h00);
        send_item(lmss_pkg::CMD_WRITE, 3'd5, 8'hA5);
        send_item(lmss_pkg::CMD_WRITE, 3'd2, 8'h5A);
        // tick fields other than cmd carry noise and must not matter
        send_item(lmss_pkg::CMD_TICK, 3'd7, 8'hFF);
        send_item(lmss_pkg::CMD_TICK, 3'd3, 8'h3C);
        send_item(lmss_pkg::CMD_TICK, 3'd0, 8'h00);
    endtask

    task automatic test_register_extremes();
        set_scan_rate(16'hFFFF, 8'hFF);
        repeat (3) send_item(lmss_pkg::CMD_TICK, 3'd0, 8'h00);
        send_item(lmss_pkg::CMD_WRITE, 3'd4, 8'h81);
        wait_drained();
        write_register(REG_UNUSED, 16'hFFFF);
        repeat (3) send_item(lmss_pkg::CMD_TICK, 3'd1, 8'h01);
        // zero settings act as one
        set_scan_rate(16'd0, 8'd0);
        repeat (6) send_item(lmss_pkg::CMD_TICK, 3'd6, 8'h7E);
    endtask

    task automatic test_random_scroll();
        int phase;
        phase = 0;
        while ((random_items < ITEM_TARGET || chars_scrolled < 1) && random_items < ITEM_CAP)
        begin
            case (phase % 8)
                0: set_scan_rate(16'd1, 8'd1);
                1: set_scan_rate(16'd0, 8'd0);
                2: set_scan_rate(16'd2, 8'd1);
                3: set_scan_rate(16'd1, 8'd1);
                4: set_scan_rate(16'hFFFF, 8'hFF);
                5: set_scan_rate(16'd0, 8'd1);
                6: set_scan_rate(16'd1, 8'd2);
                default: set_scan_rate(16'($urandom_range(1, 3)), 8'($urandom_range(0, 2)));
            endcase
            // every third phase runs without idling on either side
            send_gap_max = (phase % 3 == 2) ? 0 : 4;
            recv_gap_max = (phase % 3 == 2) ? 0 : 4;
            repeat (PHASE_ITEMS)
            begin
                send_random_item();
                random_items++;
            end
            phase++;
        end
    endtask

    task automatic test_backpressure();
        set_scan_rate(16'd1, 8'd1);
        send_gap_max = 0;
        recv_gap_max = 0;
        hold_off_left = 150;
        repeat (60)
        begin
            send_random_item();
            random_items++;
        end
        send_gap_max = 4;
        recv_gap_max = 4;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 16'd0;
        s_tuser        = lmss_pkg::CMD_TICK;
        cfg_valid      = 1'b0;
        cfg_index      = lmss_pkg::REG_DWELL_TICKS;
        cfg_data       = '0;
        error_count    = 0;
        cycle_count    = 0;
        random_items   = 0;
        chars_scrolled = 0;
        send_gap_max   = 4;
        recv_gap_max   = 4;
        ready_wait     = 0;
        hold_off_left  = 0;
        scan_row_q     = 3'd0;
        scan_col_q     = 3'd0;
        dwell_cnt      = 16'd0;
        frame_cnt      = 8'd0;
        shift_idx      = 3'd0;
        dwell_setting  = lmss_pkg::DWELL_RESET;
        frames_setting = lmss_pkg::FRAMES_RESET;
        for (int i = 0; i < 8; i++)
        begin
            lit_frame[i]  = 8'd0;
            glyph_rows[i] = 8'd0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_register_extremes();
        test_backpressure();
        test_random_scroll();

        wait_drained();
        if (expected_drive_q.size() != 0)
            report_mismatch("results never delivered", 0, expected_drive_q.size());
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
